// File: sv/frustum_box_cull_unit_assert.svh
// ----------------------------------------------------------------------------
// frustum box cull assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH

// same-cycle implication
`define FCULL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcull assertion failed");

// next-cycle implication
`define FCULL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcull assertion failed");

`endif

// File: sv/fcull_pkg.sv
// ----------------------------------------------------------------------------
// fcull_pkg
// shared types and constants of the frustum box cull unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcull_pkg;

    localparam int PLANE_COUNT = 5;
    localparam int SLOT_W      = 3;
    localparam int NRM_W       = 18;
    localparam int CRD_W       = 32;
    localparam int PROD_W      = NRM_W + CRD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_W      = 16;
    localparam int CELL_STAGES = 3;
    localparam int LATENCY     = CELL_STAGES * PLANE_COUNT;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic                    opcode;
        slot_t                   plane_slot;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic signed [CRD_W-1:0] plane_offset;
        logic signed [CRD_W-1:0] box_min_x;
        logic signed [CRD_W-1:0] box_min_y;
        logic signed [CRD_W-1:0] box_min_z;
        logic signed [CRD_W-1:0] box_max_x;
        logic signed [CRD_W-1:0] box_max_y;
        logic signed [CRD_W-1:0] box_max_z;
    } beat_t;

endpackage

// File: sv/fcull_cell.sv
// ----------------------------------------------------------------------------
// fcull_cell
// one plane of the chain: holds the plane, tests passing boxes against it
// and hands every beat on to the next cell after three stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frustum_box_cull_unit_assert.svh"

module fcull_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  fcull_pkg::slot_t  cell_id,
    input  logic              in_valid,
    input  fcull_pkg::beat_t  in_beat,
    input  logic              in_vis,
    output logic              out_valid,
    output fcull_pkg::beat_t  out_beat,
    output logic              out_vis
);
    import fcull_pkg::*;

    logic signed [NRM_W-1:0]  nrm_reg [3];
    logic signed [CRD_W-1:0]  offset_reg;

    logic signed [NRM_W-1:0]  nrm_in [3];
    logic signed [CRD_W-1:0]  lo_in [3];
    logic signed [CRD_W-1:0]  hi_in [3];
    logic                     load_hit;

    logic signed [PROD_W-1:0] prod_lo_next [3];
    logic signed [PROD_W-1:0] prod_hi_next [3];

    logic                     s1_valid_reg;
    beat_t                    s1_beat_reg;
    logic                     s1_vis_reg;
    logic signed [PROD_W-1:0] s1_lo_reg [3];
    logic signed [PROD_W-1:0] s1_hi_reg [3];
    logic signed [CRD_W-1:0]  s1_offset_reg;

    logic signed [PROD_W-1:0] max_next [3];

    logic                     s2_valid_reg;
    beat_t                    s2_beat_reg;
    logic                     s2_vis_reg;
    logic signed [PROD_W-1:0] s2_max_reg [3];
    logic signed [CRD_W-1:0]  s2_offset_reg;

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  thr_next;
    logic                     vis_next;

    logic                     s3_valid_reg;
    beat_t                    s3_beat_reg;
    logic                     s3_vis_reg;

    assign nrm_in[0] = in_beat.normal_x;
    assign nrm_in[1] = in_beat.normal_y;
    assign nrm_in[2] = in_beat.normal_z;
    assign lo_in[0]  = in_beat.box_min_x;
    assign lo_in[1]  = in_beat.box_min_y;
    assign lo_in[2]  = in_beat.box_min_z;
    assign hi_in[0]  = in_beat.box_max_x;
    assign hi_in[1]  = in_beat.box_max_y;
    assign hi_in[2]  = in_beat.box_max_z;

    assign load_hit = in_valid && (in_beat.opcode == OP_LOAD) && (in_beat.plane_slot == cell_id);

    // plane storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nrm_reg[k] <= '0;
            end
            offset_reg <= '0;
        end
        else if (load_hit)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nrm_reg[k] <= nrm_in[k];
            end
            offset_reg <= in_beat.plane_offset;
        end
    end

    // stage 1: products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_lo_next[k] = PROD_W'(nrm_reg[k]) * PROD_W'(lo_in[k]);
            prod_hi_next[k] = PROD_W'(nrm_reg[k]) * PROD_W'(hi_in[k]);
        end
    end

    // stage 2: per-axis maximum
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            max_next[k] = (s1_lo_reg[k] > s1_hi_reg[k]) ? s1_lo_reg[k] : s1_hi_reg[k];
        end
    end

    // stage 3: sum and compare with scaled offset
    always_comb
    begin
        sum_next = SUM_W'(s2_max_reg[0]) + SUM_W'(s2_max_reg[1]) + SUM_W'(s2_max_reg[2]);
        thr_next = SUM_W'($signed({s2_offset_reg, {FRAC_W{1'b0}}}));
        vis_next = s2_vis_reg && !(sum_next < thr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_beat_reg   <= in_beat;
        s1_vis_reg    <= in_vis;
        s1_offset_reg <= offset_reg;
        for (int k = 0; k < 3; k++)
        begin
            s1_lo_reg[k]  <= prod_lo_next[k];
            s1_hi_reg[k]  <= prod_hi_next[k];
            s2_max_reg[k] <= max_next[k];
        end
        s2_beat_reg   <= s1_beat_reg;
        s2_vis_reg    <= s1_vis_reg;
        s2_offset_reg <= s1_offset_reg;
        s3_beat_reg   <= s2_beat_reg;
        s3_vis_reg    <= vis_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_beat  = s3_beat_reg;
    assign out_vis   = s3_vis_reg;

    `FCULL_ASSERT_NEXT(a_load_takes, load_hit, offset_reg == $past(in_beat.plane_offset))
    `FCULL_ASSERT_IMPL(a_beat_flow, out_valid, $past(in_valid, CELL_STAGES))
    `FCULL_ASSERT_IMPL(a_vis_only_falls, out_valid && out_vis, $past(in_vis, CELL_STAGES))

endmodule

// File: sv/frustum_box_cull_unit.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_unit
// a test result strobes on done once its beat has passed the stages of every plane cell
// throughput: one beat per cycle, loads and tests alike; busy stays low
// loads ride the cell chain, so each test sees exactly the planes loaded before it
// reset clears all planes to zero, so every box is visible until planes are loaded
// results cannot be stalled: done and visible hold for a single cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frustum_box_cull_unit_assert.svh"

module frustum_box_cull_unit (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic                                       opcode,
    input  fcull_pkg::slot_t                           plane_slot,
    input  logic signed [fcull_pkg::NRM_W-1:0]         normal_x,
    input  logic signed [fcull_pkg::NRM_W-1:0]         normal_y,
    input  logic signed [fcull_pkg::NRM_W-1:0]         normal_z,
    input  logic signed [fcull_pkg::CRD_W-1:0]         plane_offset,
    input  logic signed [fcull_pkg::CRD_W-1:0]         box_min_x,
    input  logic signed [fcull_pkg::CRD_W-1:0]         box_min_y,
    input  logic signed [fcull_pkg::CRD_W-1:0]         box_min_z,
    input  logic signed [fcull_pkg::CRD_W-1:0]         box_max_x,
    input  logic signed [fcull_pkg::CRD_W-1:0]         box_max_y,
    input  logic signed [fcull_pkg::CRD_W-1:0]         box_max_z,
    output logic                                       done,
    output logic                                       visible
);
    import fcull_pkg::*;

    logic  chain_valid [PLANE_COUNT+1];
    beat_t chain_beat  [PLANE_COUNT+1];
    logic  chain_vis   [PLANE_COUNT+1];

    assign busy = 1'b0;

    assign chain_valid[0] = start && !busy;
    assign chain_vis[0]   = 1'b1;

    always_comb
    begin
        chain_beat[0].opcode       = opcode;
        chain_beat[0].plane_slot   = plane_slot;
        chain_beat[0].normal_x     = normal_x;
        chain_beat[0].normal_y     = normal_y;
        chain_beat[0].normal_z     = normal_z;
        chain_beat[0].plane_offset = plane_offset;
        chain_beat[0].box_min_x    = box_min_x;
        chain_beat[0].box_min_y    = box_min_y;
        chain_beat[0].box_min_z    = box_min_z;
        chain_beat[0].box_max_x    = box_max_x;
        chain_beat[0].box_max_y    = box_max_y;
        chain_beat[0].box_max_z    = box_max_z;
    end

    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_cell
        fcull_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (slot_t'(g)),
            .in_valid  (chain_valid[g]),
            .in_beat   (chain_beat[g]),
            .in_vis    (chain_vis[g]),
            .out_valid (chain_valid[g+1]),
            .out_beat  (chain_beat[g+1]),
            .out_vis   (chain_vis[g+1])
        );
    end

    assign done    = chain_valid[PLANE_COUNT] && (chain_beat[PLANE_COUNT].opcode == OP_TEST);
    assign visible = chain_vis[PLANE_COUNT];

    `FCULL_ASSERT_IMPL(a_done_from_test, done, $past(start && !busy && (opcode == OP_TEST), LATENCY))
    `FCULL_ASSERT_IMPL(a_busy_low, 1'b1, !busy)
    `FCULL_ASSERT_IMPL(a_visible_known, done, !$isunknown(visible))

endmodule
